/* rtl/core/fsfm_pkg.sv */
// Shared types and constants for the dual sensor failover monitor.
`timescale 1ns / 1ps
`default_nettype none

package fsfm_pkg;

  localparam int DIST_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 4;

  localparam int TOL_WIDTH     = 16;
  localparam int LIMIT_WIDTH   = 4;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOLERANCE   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DIVERGE_LIM = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_STUCK_LIM   = 2'd2;

  localparam logic [TOL_WIDTH-1:0]   TOLERANCE_RST   = 16'd10;
  localparam logic [LIMIT_WIDTH-1:0] DIVERGE_LIM_RST = 4'd3;
  localparam logic [LIMIT_WIDTH-1:0] STUCK_LIM_RST   = 4'd5;

  typedef enum logic [1:0] {
    HEALTH_OK        = 2'd0,
    HEALTH_DIVERGENT = 2'd1,
    HEALTH_STUCK     = 2'd2
  } health_t;

  typedef struct packed {
    logic [TOL_WIDTH-1:0]   tolerance;
    logic [LIMIT_WIDTH-1:0] diverge_limit;
    logic [LIMIT_WIDTH-1:0] stuck_limit;
  } cfg_t;

  typedef struct packed {
    logic    use_backup;
    health_t primary_health;
    health_t backup_health;
    logic    warn_flag;
  } flags_t;

endpackage

`default_nettype wire

/* rtl/core/fsfm_cfg_regs.sv */
// Configuration register file: tolerance and the two run limits.
`timescale 1ns / 1ps
`default_nettype none

module fsfm_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                wr_en,
  input  wire logic [fsfm_pkg::CFG_IDX_WIDTH-1:0]  wr_index,
  input  wire logic [fsfm_pkg::TOL_WIDTH-1:0]      wr_data,
  output fsfm_pkg::cfg_t                           cfg
);
  import fsfm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance     <= TOLERANCE_RST;
      cfg_r.diverge_limit <= DIVERGE_LIM_RST;
      cfg_r.stuck_limit   <= STUCK_LIM_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TOLERANCE:   cfg_r.tolerance     <= wr_data;
        CFG_DIVERGE_LIM: cfg_r.diverge_limit <= wr_data[LIMIT_WIDTH-1:0];
        CFG_STUCK_LIM:   cfg_r.stuck_limit   <= wr_data[LIMIT_WIDTH-1:0];
        default: ;  // unmapped index, drop the word
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/fsfm_check.sv */
// Per-check update: agreement test, run counters, health and failover decision.
`timescale 1ns / 1ps
`default_nettype none

module fsfm_check #(
  parameter int DIST_WIDTH  = fsfm_pkg::DIST_WIDTH_DEF,
  parameter int COUNT_WIDTH = fsfm_pkg::COUNT_WIDTH_DEF
) (
  input  wire fsfm_pkg::cfg_t            cfg,
  input  wire logic [DIST_WIDTH-1:0]     primary,
  input  wire logic [DIST_WIDTH-1:0]     backup,
  input  wire logic [DIST_WIDTH-1:0]     prev_primary,
  input  wire logic [DIST_WIDTH-1:0]     prev_backup,
  input  wire logic [COUNT_WIDTH-1:0]    diverge_run,
  input  wire logic [COUNT_WIDTH-1:0]    primary_run,
  input  wire logic [COUNT_WIDTH-1:0]    backup_run,
  input  wire fsfm_pkg::flags_t          flags,
  output logic [COUNT_WIDTH-1:0]         diverge_run_nxt,
  output logic [COUNT_WIDTH-1:0]         primary_run_nxt,
  output logic [COUNT_WIDTH-1:0]         backup_run_nxt,
  output fsfm_pkg::flags_t               flags_nxt,
  output logic [DIST_WIDTH-1:0]          sel_distance
);
  import fsfm_pkg::*;

  localparam int DIFF_W = DIST_WIDTH + 1;
  localparam int CMP_W  = (DIFF_W > TOL_WIDTH) ? DIFF_W : TOL_WIDTH;
  localparam int RUN_W  = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] abs_diff;
  logic                     agree;

  // exact difference, one guard bit so it never wraps
  assign diff     = $signed({primary[DIST_WIDTH-1], primary})
                  - $signed({backup[DIST_WIDTH-1], backup});
  assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign agree    = CMP_W'(abs_diff) <= CMP_W'(cfg.tolerance);

  always_comb begin
    logic    ub;
    logic    wf;
    health_t ph;
    health_t bh;
    ub = flags.use_backup;
    wf = flags.warn_flag;
    ph = flags.primary_health;
    bh = flags.backup_health;

    // divergence run: blame whichever encoder is active
    if (!agree) begin
      diverge_run_nxt = (&diverge_run) ? diverge_run : diverge_run + 1'b1;
      if (RUN_W'(diverge_run_nxt) >= RUN_W'(cfg.diverge_limit)) begin
        if (!ub) begin
          ph = HEALTH_DIVERGENT;
          ub = 1'b1;
          wf = 1'b1;
        end else begin
          bh = HEALTH_DIVERGENT;
        end
      end
    end else begin
      diverge_run_nxt = '0;
      if (ph == HEALTH_DIVERGENT) ph = HEALTH_OK;
      if (bh == HEALTH_DIVERGENT) bh = HEALTH_OK;
    end

    if (primary == prev_primary) begin
      primary_run_nxt = (&primary_run) ? primary_run : primary_run + 1'b1;
      if (RUN_W'(primary_run_nxt) >= RUN_W'(cfg.stuck_limit) && !ub) begin
        ph = HEALTH_STUCK;
        ub = 1'b1;
        wf = 1'b1;
      end
    end else begin
      primary_run_nxt = '0;
      if (ph == HEALTH_STUCK) ph = HEALTH_OK;
    end

    if (backup == prev_backup) begin
      backup_run_nxt = (&backup_run) ? backup_run : backup_run + 1'b1;
      if (RUN_W'(backup_run_nxt) >= RUN_W'(cfg.stuck_limit) && ub) begin
        bh = HEALTH_STUCK;
      end
    end else begin
      backup_run_nxt = '0;
      if (bh == HEALTH_STUCK) bh = HEALTH_OK;
    end

    // restore covers both the stuck-backup attempt and the regular return
    if (ub && ph == HEALTH_OK && agree) begin
      ub = 1'b0;
      wf = 1'b0;
    end

    flags_nxt.use_backup     = ub;
    flags_nxt.warn_flag      = wf;
    flags_nxt.primary_health = ph;
    flags_nxt.backup_health  = bh;
  end

  assign sel_distance = flags_nxt.use_backup ? backup : primary;

endmodule

`default_nettype wire

/* rtl/core/dual_sensor_failover_monitor.sv */
// The accepted word waits in the input register, then moves to the result register and raises out_valid.
// Throughput: one word per cycle; while a finished word waits on out_ready the
// input register takes one more word, then in_ready drops until the result moves.
// Reset (rst_n low, synchronous): both stages empty, registers back to their
// defaults (tolerance 10, limits 3 and 5), primary selected, both statuses ok.
`timescale 1ns / 1ps
`default_nettype none

module dual_sensor_failover_monitor #(
  parameter int DIST_WIDTH  = fsfm_pkg::DIST_WIDTH_DEF,
  parameter int COUNT_WIDTH = fsfm_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [DIST_WIDTH-1:0]        in_primary_distance,
  input  wire logic signed [DIST_WIDTH-1:0]        in_backup_distance,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_backup_active,
  output logic [1:0]                               out_primary_state,
  output logic [1:0]                               out_backup_state,
  output logic                                     out_healthy,
  output logic                                     out_warning,
  output logic signed [DIST_WIDTH-1:0]             out_selected_distance,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fsfm_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [fsfm_pkg::TOL_WIDTH-1:0]      cfg_data
);
  import fsfm_pkg::*;

  cfg_t cfg;

  logic                   in_valid_r;
  logic [DIST_WIDTH-1:0]  primary_r;
  logic [DIST_WIDTH-1:0]  backup_r;

  logic [DIST_WIDTH-1:0]  prev_primary_r;
  logic [DIST_WIDTH-1:0]  prev_backup_r;
  logic [COUNT_WIDTH-1:0] diverge_run_r;
  logic [COUNT_WIDTH-1:0] primary_run_r;
  logic [COUNT_WIDTH-1:0] backup_run_r;
  flags_t                 flags_r;

  logic [COUNT_WIDTH-1:0] diverge_run_nxt;
  logic [COUNT_WIDTH-1:0] primary_run_nxt;
  logic [COUNT_WIDTH-1:0] backup_run_nxt;
  flags_t                 flags_nxt;
  logic [DIST_WIDTH-1:0]  sel_distance;

  logic                   out_valid_r;
  flags_t                 out_flags_r;
  logic [DIST_WIDTH-1:0]  out_dist_r;

  logic out_free;
  logic advance;
  logic in_fire;

  assign cfg_ready = 1'b1;

  fsfm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fsfm_check #(
    .DIST_WIDTH  (DIST_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_check (
    .cfg             (cfg),
    .primary         (primary_r),
    .backup          (backup_r),
    .prev_primary    (prev_primary_r),
    .prev_backup     (prev_backup_r),
    .diverge_run     (diverge_run_r),
    .primary_run     (primary_run_r),
    .backup_run      (backup_run_r),
    .flags           (flags_r),
    .diverge_run_nxt (diverge_run_nxt),
    .primary_run_nxt (primary_run_nxt),
    .backup_run_nxt  (backup_run_nxt),
    .flags_nxt       (flags_nxt),
    .sel_distance    (sel_distance)
  );

  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      primary_r <= in_primary_distance;
      backup_r  <= in_backup_distance;
    end
  end

  // monitor state advances once per word as it moves into the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_primary_r         <= '0;
      prev_backup_r          <= '0;
      diverge_run_r          <= '0;
      primary_run_r          <= '0;
      backup_run_r           <= '0;
      flags_r.use_backup     <= 1'b0;
      flags_r.warn_flag      <= 1'b0;
      flags_r.primary_health <= HEALTH_OK;
      flags_r.backup_health  <= HEALTH_OK;
    end else if (advance) begin
      prev_primary_r <= primary_r;
      prev_backup_r  <= backup_r;
      diverge_run_r  <= diverge_run_nxt;
      primary_run_r  <= primary_run_nxt;
      backup_run_r   <= backup_run_nxt;
      flags_r        <= flags_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags_r <= flags_nxt;
      out_dist_r  <= sel_distance;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_backup_active     = out_flags_r.use_backup;
  assign out_primary_state     = out_flags_r.primary_health;
  assign out_backup_state      = out_flags_r.backup_health;
  assign out_healthy           = (out_flags_r.primary_health == HEALTH_OK)
                              || (out_flags_r.backup_health == HEALTH_OK);
  assign out_warning           = out_flags_r.warn_flag;
  assign out_selected_distance = out_dist_r;

endmodule

`default_nettype wire

/* dv/dual_sensor_failover_monitor_test.sv */
// Self-checking testbench for the dual sensor failover monitor.
`timescale 1ns / 1ps

module dual_sensor_failover_monitor_test;
  import fsfm_pkg::*;

  localparam int DW                = DIST_WIDTH_DEF;
  localparam int CW                = COUNT_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int PHASE_ITEMS       = 222;
  localparam int PHASES            = 8;
  localparam int DRAIN_CYCLES      = 4;

  typedef struct packed {
    logic [DW-1:0] primary;
    logic [DW-1:0] backup;
  } check_word_t;

  typedef struct packed {
    logic          backup_active;
    logic [1:0]    primary_state;
    logic [1:0]    backup_state;
    logic          healthy;
    logic          warning;
    logic [DW-1:0] selected_distance;
  } check_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] in_primary_distance = '0;
  logic signed [DW-1:0] in_backup_distance = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_backup_active;
  logic [1:0]           out_primary_state;
  logic [1:0]           out_backup_state;
  logic                 out_healthy;
  logic                 out_warning;
  logic signed [DW-1:0] out_selected_distance;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = CFG_TOLERANCE;
  logic [TOL_WIDTH-1:0]     cfg_data = '0;

  dual_sensor_failover_monitor DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_primary_distance   (in_primary_distance),
    .in_backup_distance    (in_backup_distance),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_backup_active     (out_backup_active),
    .out_primary_state     (out_primary_state),
    .out_backup_state      (out_backup_state),
    .out_healthy           (out_healthy),
    .out_warning           (out_warning),
    .out_selected_distance (out_selected_distance),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #2 clk = ~clk;

  // Monitor state as the block should hold it.
  logic [TOL_WIDTH-1:0]   tol_reg = TOLERANCE_RST;
  logic [LIMIT_WIDTH-1:0] diverge_lim = DIVERGE_LIM_RST;
  logic [LIMIT_WIDTH-1:0] stuck_lim = STUCK_LIM_RST;
  logic [DW-1:0]          last_primary = '0;
  logic [DW-1:0]          last_backup = '0;
  logic [CW-1:0]          disagree_run = '0;
  logic [CW-1:0]          primary_still = '0;
  logic [CW-1:0]          backup_still = '0;
  logic                   on_backup = 1'b0;
  logic                   warn_latched = 1'b0;
  health_t                primary_health = HEALTH_OK;
  health_t                backup_health = HEALTH_OK;

  check_word_t   pending_checks[$];
  check_result_t expected_results[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned idle_count = 0;
  int unsigned long_stall_asks = 0;
  int unsigned long_stall_seen = 0;
  int unsigned hold_cycles = 0;
  int unsigned ready_left = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  check_word_t   next_word;
  check_result_t seen, want;

  logic [DW-1:0] gen_primary = 32'd1000;
  logic [DW-1:0] gen_backup = 32'd1000;

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic check_result_t evaluate_check(input logic [DW-1:0] p,
                                                   input logic [DW-1:0] b);
    longint        sp, sb, gap;
    logic          agree;
    check_result_t r;
    sp = longint'($signed(p));
    sb = longint'($signed(b));
    gap = (sp >= sb) ? sp - sb : sb - sp;
    agree = (gap <= longint'(tol_reg));

    if (!agree) begin
      disagree_run = bump(disagree_run);
      if (disagree_run >= diverge_lim) begin
        if (!on_backup) begin
          primary_health = HEALTH_DIVERGENT;
          on_backup = 1'b1;
          warn_latched = 1'b1;
        end else begin
          backup_health = HEALTH_DIVERGENT;
        end
      end
    end else begin
      disagree_run = '0;
      if (primary_health == HEALTH_DIVERGENT) primary_health = HEALTH_OK;
      if (backup_health == HEALTH_DIVERGENT) backup_health = HEALTH_OK;
    end

    if (p == last_primary) begin
      primary_still = bump(primary_still);
      if (primary_still >= stuck_lim && !on_backup) begin
        primary_health = HEALTH_STUCK;
        on_backup = 1'b1;
        warn_latched = 1'b1;
      end
    end else begin
      primary_still = '0;
      if (primary_health == HEALTH_STUCK) primary_health = HEALTH_OK;
    end

    if (b == last_backup) begin
      backup_still = bump(backup_still);
      if (backup_still >= stuck_lim && on_backup) backup_health = HEALTH_STUCK;
    end else begin
      backup_still = '0;
      if (backup_health == HEALTH_STUCK) backup_health = HEALTH_OK;
    end

    // A stuck backup asks for the same restore as the closing check, so one covers both.
    if (on_backup && primary_health == HEALTH_OK && agree) begin
      on_backup = 1'b0;
      warn_latched = 1'b0;
    end

    last_primary = p;
    last_backup = b;

    r.backup_active = on_backup;
    r.primary_state = primary_health;
    r.backup_state = backup_health;
    r.healthy = (primary_health == HEALTH_OK) || (backup_health == HEALTH_OK);
    r.warning = warn_latched;
    r.selected_distance = on_backup ? b : p;
    return r;
  endfunction

  function automatic logic [DW-1:0] near(input logic [DW-1:0] base, input int unsigned mag);
    return ($urandom_range(0, 1) == 0) ? base + DW'(mag) : base - DW'(mag);
  endfunction

  function automatic logic [DW-1:0] extreme_value();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h8000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic queue_check(input logic [DW-1:0] p, input logic [DW-1:0] b);
    pending_checks.push_back('{primary: p, backup: b});
  endtask

  // One stretch of related checks: tracking, divergence, frozen readings or noise.
  task automatic add_episode();
    int unsigned kind, len, step, agree_mag, split_mag;
    kind = $urandom_range(0, 11);
    len = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 60);
      agree_mag = ($urandom_range(0, 4) == 0) ? tol_reg : $urandom_range(0, tol_reg);
      split_mag = tol_reg + 1 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 100000));
      case (kind)
        0, 1, 2: begin
          gen_primary += DW'(step);
          gen_backup = near(gen_primary, agree_mag);
        end
        3: begin
          gen_primary += DW'(step);
          gen_backup = near(gen_primary, split_mag);
        end
        4, 5: gen_backup = near(gen_primary, agree_mag);
        6, 7: gen_primary = near(gen_backup, agree_mag);
        8: ;
        9: gen_backup = near(gen_primary, split_mag);
        10: begin
          gen_primary = $urandom;
          gen_backup = $urandom;
        end
        default: begin
          gen_primary = extreme_value();
          gen_backup = extreme_value();
        end
      endcase
      queue_check(gen_primary, gen_backup);
    end
  endtask

  task automatic apply_settings(input logic [TOL_WIDTH-1:0] tol,
                                input logic [TOL_WIDTH-1:0] div_w,
                                input logic [TOL_WIDTH-1:0] stk_w);
    logic [TOL_WIDTH-1:0]     vals[3];
    logic [CFG_IDX_WIDTH-1:0] idxs[3];
    vals = '{tol, div_w, stk_w};
    idxs = '{CFG_TOLERANCE, CFG_DIVERGE_LIM, CFG_STUCK_LIM};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idxs[i])
        CFG_TOLERANCE:   tol_reg = vals[i];
        CFG_DIVERGE_LIM: diverge_lim = vals[i][LIMIT_WIDTH-1:0];
        default:         stuck_lim = vals[i][LIMIT_WIDTH-1:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_checks.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(evaluate_check(in_primary_distance, in_backup_distance));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_checks.size() > 0) begin
          next_word = pending_checks.pop_front();
          in_valid <= 1'b1;
          in_primary_distance <= next_word.primary;
          in_backup_distance <= next_word.backup;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random ready pattern, plus one long hold when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (long_stall_seen != long_stall_asks) begin
      long_stall_seen = long_stall_asks;
      hold_cycles = LONG_STALL_CYCLES;
      out_ready <= 1'b0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      ready_left = $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
      ready_left = $urandom_range(0, 40);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        seen = '{out_backup_active, out_primary_state, out_backup_state, out_healthy,
                 out_warning, out_selected_distance};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"word %0d: expected sel=%0b pri=%0d bak=%0d ok=%0b warn=%0b dist=%0d,",
                        " got sel=%0b pri=%0d bak=%0d ok=%0b warn=%0b dist=%0d"},
                       results_seen, want.backup_active, want.primary_state,
                       want.backup_state, want.healthy, want.warning,
                       $signed(want.selected_distance), seen.backup_active,
                       seen.primary_state, seen.backup_state, seen.healthy,
                       seen.warning, $signed(seen.selected_distance));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_count = 0;
      end else begin
        idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
          $display("[dual_sensor_failover_monitor] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [TOL_WIDTH-1:0] tol_w, div_w, stk_w;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks at reset settings.
    queue_check(32'd0, 32'd0);                  // zero on the first check is unchanged
    queue_check(32'd100, 32'd110);              // difference right at tolerance
    queue_check(32'd200, 32'd189);              // one past tolerance
    queue_check(32'h7FFF_FFFF, 32'h8000_0000);  // widest difference
    queue_check(32'h8000_0000, 32'h7FFF_FFFF);  // third miss: fail over
    queue_check(32'd300, 32'd300);              // agree again: restore
    for (int i = 1; i <= 5; i++) queue_check(32'd300, 32'd300 + i);  // primary frozen
    for (int i = 0; i < 5; i++) queue_check(32'd300, 32'd305);       // both frozen
    queue_check(32'd400, 32'd405);
    queue_check(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_check(32'd0, 32'd65535);
    queue_check(32'hFFFF_FFF6, 32'd0);
    queue_check(32'd5, 32'hFFFF_FFFB);
    queue_check(32'h8000_0000, 32'h8000_0000);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin tol_w = 16'd10;     div_w = 16'd3;      stk_w = 16'd5;      end
        1: begin tol_w = 16'd0;      div_w = 16'd1;      stk_w = 16'd1;      end
        2: begin tol_w = 16'hFFFF;   div_w = 16'd15;     stk_w = 16'd15;     end
        3: begin tol_w = 16'd5;      div_w = 16'hFFF0;   stk_w = 16'h1230;   end
        4: begin
          tol_w = 16'($urandom_range(0, 40));
          div_w = 16'hABC2;
          stk_w = 16'h5557;
        end
        5: begin
          tol_w = 16'($urandom);
          div_w = {12'($urandom), 4'($urandom_range(1, 15))};
          stk_w = {12'($urandom), 4'($urandom_range(1, 15))};
        end
        6: begin
          tol_w = 16'($urandom_range(0, 200));
          div_w = 16'($urandom);
          stk_w = 16'($urandom);
        end
        default: begin tol_w = 16'd20; div_w = 16'd15; stk_w = 16'd1; end
      endcase
      apply_settings(tol_w, div_w, stk_w);
      while (pending_checks.size() < PHASE_ITEMS) add_episode();
      // Hold the result side off while words keep coming, so the input backs up.
      if (ph == 4) long_stall_asks++;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("[dual_sensor_failover_monitor] OK");
    end else begin
      $display("[dual_sensor_failover_monitor] ERROR");
    end
    $finish;
  end

endmodule
